@@ rtl/mhs_pkg.sv @@
// ----------------------------------------------------------------------------
// mhs_pkg: shared types and constants of the max-heap sort engine
// Item payloads, the command broadcast to the cell row, the link between
// neighbouring cells and the controller states.
// ----------------------------------------------------------------------------
package mhs_pkg;

    localparam int MHS_CAPACITY = 32;
    localparam int MHS_DATA_W   = 32;

    // One loaded item.
    typedef struct packed {
        logic signed [MHS_DATA_W-1:0] value;
        logic                         last;
    } load_t;

    // One emitted item.
    typedef struct packed {
        logic signed [MHS_DATA_W-1:0] value_res;
        logic                         last_res;
        logic                         truncated;
    } emit_t;

    // Command seen by every cell in the same cycle.
    typedef struct packed {
        logic                         push;
        logic                         pop;
        logic signed [MHS_DATA_W-1:0] value;
    } cell_cmd_t;

    // What one cell shows to its neighbours.
    typedef struct packed {
        logic                         vld;
        logic signed [MHS_DATA_W-1:0] value;
        logic                         take;
    } cell_link_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } mhs_state_t;

endpackage

@@ rtl/mhs_cell.sv @@
// ----------------------------------------------------------------------------
// mhs_cell: one cell of the sorted row
// Holds one value and its valid flag. The row is kept in descending order,
// with empty cells at the far end.
// ----------------------------------------------------------------------------
module mhs_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mhs_pkg::cell_cmd_t cmd,
    input  mhs_pkg::cell_link_t left,
    input  mhs_pkg::cell_link_t right,
    output mhs_pkg::cell_link_t link
);
    import mhs_pkg::*;

    logic                         vld_reg;
    logic                         vld_next;
    logic signed [MHS_DATA_W-1:0] val_reg;
    logic signed [MHS_DATA_W-1:0] val_next;
    logic                         take;

    // The new value belongs here or further up when this cell is empty or
    // holds a smaller value. Equal values stay ahead of the newcomer.
    assign take = cmd.push && (!vld_reg || (cmd.value > val_reg));

    always_comb
    begin
        vld_next = vld_reg;
        val_next = val_reg;
        if (cmd.pop)
        begin
            vld_next = right.vld;
            val_next = right.value;
        end
        else if (take)
        begin
            if (left.take)
            begin
                vld_next = left.vld;
                val_next = left.value;
            end
            else
            begin
                vld_next = 1'b1;
                val_next = cmd.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link.vld   = vld_reg;
    assign link.value = val_reg;
    assign link.take  = take;

endmodule

@@ rtl/max_heap_sort_engine.sv @@
// ----------------------------------------------------------------------------
// max_heap_sort_engine: batch sorter emitting values in descending order
// Loads signed values one per cycle and, after the item marked last, emits
// them largest first with the smallest one marked.
// ----------------------------------------------------------------------------
// Values enter on the load channel at one item per cycle. Each accepted
// value is placed straight into a row of CAPACITY cells that is always kept
// in descending order: every cell compares the incoming value with its own
// in the same cycle and the cells below the insertion point move down by
// one place. When the item marked last has been accepted, the load channel
// stalls and the row empties from its head at one item per cycle while
// emit_stall is low, the first result being offered in the cycle after that
// last item. Both phases rest on the single compare-and-shift step of the
// cell row. Values arriving while all CAPACITY cells are full are dropped,
// and every result of that batch then carries the truncated flag. After
// the final result has been taken the block returns to loading with an
// empty row and a clear flag, and can accept the next item in the
// following cycle.
// ----------------------------------------------------------------------------
module max_heap_sort_engine #(
    parameter int CAPACITY = mhs_pkg::MHS_CAPACITY
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load_valid,
    output logic           load_stall,
    input  mhs_pkg::load_t load_item,
    output logic           emit_valid,
    input  logic           emit_stall,
    output mhs_pkg::emit_t emit_item
);
    import mhs_pkg::*;

    mhs_state_t state_reg;
    mhs_state_t state_next;
    logic       overflow_reg;
    logic       overflow_next;

    cell_cmd_t  cmd;
    cell_link_t links [CAPACITY];

    logic load_fire;
    logic emit_fire;
    logic row_full;
    logic final_item;

    // The row is full exactly when its far cell holds a value.
    assign row_full   = links[CAPACITY-1].vld;

    assign load_stall = (state_reg != ST_LOAD);
    assign load_fire  = load_valid && !load_stall;

    // The head cell is a register, so results leave straight from it.
    assign emit_valid = (state_reg == ST_DRAIN) && links[0].vld;
    assign emit_fire  = emit_valid && !emit_stall;
    assign final_item = !links[1].vld;

    assign emit_item.value_res = links[0].value;
    assign emit_item.last_res  = final_item;
    assign emit_item.truncated = overflow_reg;

    assign cmd.push  = load_fire && !row_full;
    assign cmd.pop   = emit_fire;
    assign cmd.value = load_item.value;

    // Build the row; the ends see an empty neighbour that never takes.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        cell_link_t left_link;
        cell_link_t right_link;

        if (g == 0)
        begin : g_head
            assign left_link = '0;
        end
        else
        begin : g_inner_left
            assign left_link = links[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_link = '0;
        end
        else
        begin : g_inner_right
            assign right_link = links[g+1];
        end

        mhs_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_link),
            .right (right_link),
            .link  (links[g])
        );
    end

    // Loading continues until the item marked last; draining ends when the
    // final result has been taken.
    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_fire)
                begin
                    if (row_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (load_item.last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (emit_fire && final_item)
                begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next    = ST_LOAD;
                overflow_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

@@ dv/mhs_sort_board.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_sort_board: running prediction of the max-heap sort engine
// Keeps a private copy of the value store, sorts each batch with a
// bottom-up heap procedure and checks every emitted item.
// ----------------------------------------------------------------------------
package mhs_tb_pkg;

    import mhs_pkg::*;

    typedef logic signed [MHS_DATA_W-1:0] sample_t;

    class sorted_run_board;

        // Heap positions are 1-based; entry 0 is unused.
        sample_t heap [MHS_CAPACITY+1];
        int      held;
        bit      dropped;
        emit_t   sorted_due [$];
        int      errors;

        function new();
            held    = 0;
            dropped = 1'b0;
            errors  = 0;
        endfunction

        function void swap_at(int a, int b);
            sample_t t;
            t       = heap[a];
            heap[a] = heap[b];
            heap[b] = t;
        endfunction

        // Swap down along the larger child (ties go left) to a leaf, then
        // bubble back up, never above the node where the sift began.
        function void heap_sift(int start, int n);
            int node;
            int kid;
            node = start;
            while (2 * node <= n) begin
                kid = 2 * node;
                if (kid + 1 <= n && heap[kid+1] > heap[kid])
                    kid = kid + 1;
                swap_at(node, kid);
                node = kid;
            end
            while (node > start && heap[node] > heap[node/2]) begin
                swap_at(node, node / 2);
                node = node / 2;
            end
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // Called for every accepted load item.
        function void take_load(load_t it);
            int      n;
            sample_t biggest;
            emit_t   e;
            if (held < MHS_CAPACITY) begin
                held++;
                heap[held] = it.value;
            end
            else
                dropped = 1'b1;
            if (!it.last)
                return;
            n = held;
            for (int i = n / 2; i > 0; i--)
                heap_sift(i, n);
            while (n > 0) begin
                biggest  = heap[1];
                heap[1]  = heap[n];
                heap[n]  = biggest;
                n--;
                if (n > 1)
                    heap_sift(1, n);
                e.value_res = biggest;
                e.last_res  = (n == 0);
                e.truncated = dropped;
                sorted_due.push_back(e);
            end
            held    = 0;
            dropped = 1'b0;
        endfunction

        // Called for every accepted emit item.
        function void check_emit(emit_t got);
            emit_t want;
            if (sorted_due.size() == 0) begin
                report($sformatf("unexpected item value=%0d last=%0b trunc=%0b",
                                 got.value_res, got.last_res, got.truncated));
                return;
            end
            want = sorted_due.pop_front();
            if (got.value_res !== want.value_res || got.last_res !== want.last_res
                || got.truncated !== want.truncated)
                report($sformatf({"expected value=%0d last=%0b trunc=%0b, ",
                                  "got value=%0d last=%0b trunc=%0b"},
                                 want.value_res, want.last_res, want.truncated,
                                 got.value_res, got.last_res, got.truncated));
        endfunction

        function void account_leftovers();
            if (sorted_due.size() != 0)
                report($sformatf("%0d items never emitted", sorted_due.size()));
        endfunction

    endclass

endpackage

@@ dv/max_heap_sort_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_sort_engine_tb: self-checking bench for the max-heap sort engine
// Loads batches of signed values, predicts the descending output of each
// batch and compares every emitted item, with random gaps on both channels.
// ----------------------------------------------------------------------------
module max_heap_sort_engine_tb;

    import mhs_pkg::*;
    import mhs_tb_pkg::*;

    localparam sample_t MAX_V       = 32'sh7fffffff;
    localparam sample_t MIN_V       = 32'sh80000000;
    // A generous ceiling on cycles without any accepted item. The long
    // receiver hold-off lies well below it and a full sort is far shorter.
    localparam int      STALL_LIMIT = 4000;
    localparam int      HOLD_CYCLES = 300;
    localparam int      LOAD_TARGET = 150;

    logic  clk;
    logic  rst_n;
    logic  load_valid;
    logic  load_stall;
    load_t load_item;
    logic  emit_valid;
    logic  emit_stall;
    emit_t emit_item;

    sorted_run_board board;

    // Shared between the sender and receiver processes. While steady is
    // set neither side inserts gaps; hold_req asks the receiver for one
    // long hold-off, which it then counts out itself.
    bit steady;
    bit hold_req;
    int loads_taken;

    sample_t vals [$];

    max_heap_sort_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_stall (load_stall),
        .load_item  (load_item),
        .emit_valid (emit_valid),
        .emit_stall (emit_stall),
        .emit_item  (emit_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one item from the falling edge, with random idle cycles first,
    // and hold it until the block takes it at a rising edge.
    task automatic send_load(input sample_t v, input logic is_last);
        load_t it;
        it.value = v;
        it.last  = is_last;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 16)
        begin
            load_valid <= 1'b0;
            @(negedge clk);
        end
        load_valid <= 1'b1;
        load_item  <= it;
        do
            @(posedge clk);
        while (load_stall);
        board.take_load(it);
        loads_taken++;
    endtask

    // Sends a whole batch with the final item marked last. Beyond the
    // capacity the block drops values, including a dropped last one.
    task automatic send_batch(input sample_t q [$]);
        foreach (q[i])
            send_load(q[i], i == q.size() - 1);
    endtask

    // Mixes full-range values with extremes and a narrow band around zero,
    // so that ties and sign changes occur often.
    function automatic sample_t pick_value();
        case ($urandom_range(9))
            0:       return MAX_V;
            1:       return MIN_V;
            2, 3:    return sample_t'($urandom_range(6)) - 3;
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic random_batch(input int size);
        vals.delete();
        repeat (size)
            vals.push_back(pick_value());
        send_batch(vals);
    endtask

    // Receiver: stall decided at the falling edge, items taken at the
    // rising edge.
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left  = 0;
        hold_done  = 1'b0;
        emit_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                emit_stall <= 1'b1;
                hold_left--;
            end
            else
                emit_stall <= !steady && ($urandom_range(99) < 16);
            @(posedge clk);
            if (emit_valid && !emit_stall)
                board.check_emit(emit_item);
        end
    end

    // Watchdog: ends the run if nothing moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((load_valid && !load_stall) || (emit_valid && !emit_stall) || !rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("** max_heap_sort_engine: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int size;
        board       = new();
        steady      = 1'b0;
        hold_req    = 1'b0;
        loads_taken = 0;
        rst_n       = 1'b0;
        load_valid  = 1'b0;
        load_item   = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A batch of one value, the extremes together with
        // zero and minus one (with repeated extremes as ties), a run of
        // equal values, and ascending and descending orders.
        vals = '{42};
        send_batch(vals);
        vals = '{MAX_V, MIN_V, 0, -1, 1, MIN_V, MAX_V};
        send_batch(vals);
        vals = '{5, 5, 5};
        send_batch(vals);
        vals = '{-2, -1, 0, 1, 2};
        send_batch(vals);
        vals = '{7, 3, -3, -7};
        send_batch(vals);

        // A full store first, with the receiver holding off so that the
        // block fills up and stalls its input while the next batch is
        // offered. That next batch overflows the store, and its last item
        // is itself dropped, so the sort runs over the values already held.
        hold_req = 1'b1;
        random_batch(MHS_CAPACITY);
        random_batch(MHS_CAPACITY + 3);

        // Mostly short batches, now and then one around the capacity.
        while (loads_taken < LOAD_TARGET)
        begin
            steady = (loads_taken >= 110 && loads_taken < 160);
            if ($urandom_range(7) == 0)
                size = $urandom_range(MHS_CAPACITY + 6, MHS_CAPACITY - 2);
            else
                size = $urandom_range(12, 1);
            random_batch(size);
        end
        steady = 1'b0;

        @(negedge clk);
        load_valid <= 1'b0;

        // Wait for every predicted item, then a short tail so that any
        // stray output still shows up.
        while (board.sorted_due.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        board.account_leftovers();
        if (board.errors == 0)
            $display("** max_heap_sort_engine: PASSED **");
        else
            $display("** max_heap_sort_engine: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mhs_pkg.sv
rtl/mhs_cell.sv
rtl/max_heap_sort_engine.sv
dv/mhs_sort_board.sv
dv/max_heap_sort_engine_tb.sv
